@@ rtl/core/oost_pkg.sv @@
// ----------------------------------------------------------------------------
// oost_pkg
// Shared types and operation codes for the ordered operation slot table.
// ----------------------------------------------------------------------------
package oost_pkg;

    typedef enum logic [2:0] {
        OP_ADD        = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_ALIVE      = 3'd2,
        OP_CLEAR_TYPE = 3'd3,
        OP_CLEAR_VIEW = 3'd4,
        OP_COUNT      = 3'd5,
        OP_WALK       = 3'd6,
        OP_NONE       = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [2:0]         op;
        logic [15:0]        view_key;
        logic signed [31:0] order_key;
        logic [7:0]         type_code;
        logic [31:0]        user_tag;
        logic [31:0]        param_word;
        logic [31:0]        entry_id;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        id_out;
        logic               is_alive;
        logic [4:0]         view_count;
        logic [7:0]         type_out;
        logic [31:0]        tag_out;
        logic [31:0]        param_out;
        logic signed [31:0] order_out;
        logic               last;
    } t_rsp;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // latch request, clear scan state
        logic scan;       // examine slot at scan index
        logic commit;     // apply the operation's effect after a scan
        logic walk_emit;  // emit the best candidate and mark it done
        logic walk_reset; // restart search for next walk result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic walk_more;  // another walk result is to be emitted after this one
        logic walk_empty;
    } t_sts;

endpackage

@@ rtl/core/ordered_op_slot_table.sv @@
// ----------------------------------------------------------------------------
// ordered_op_slot_table
// Table of operation slots keyed by view, with ordered walk.
// ----------------------------------------------------------------------------
// Every transaction except walk gives one result: a single pass of the scan
// unit over all slots, then a commit cycle that applies the change and
// registers the result. A walk finds each result by a fresh pass over the
// slots that picks the smallest (order, sequence) entry not yet emitted; an
// empty view gives one result after one pass. Results appear with o_valid high
// for exactly one cycle and cannot be held off. Busy stays high until the
// cycle in which the last result of the transaction is presented, so the next
// transaction can be taken at the edge that ends that cycle. Nothing needs
// clearing after reset: the slot contents are qualified by live bits that
// reset clears.
module ordered_op_slot_table #(
    parameter int SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  oost_pkg::t_req   i_req,
    output logic             o_valid,
    output oost_pkg::t_rsp   o_rsp
);
    import oost_pkg::*;

    t_cmd cmd;
    t_sts sts;

    oost_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (t_op'(i_req.op)),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    oost_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // A start taken while idle always leads to busy in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");

    // A non-final result means more of the walk is still to come.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.last) |-> busy) else $error("walk ended early");

    // Load, scan, commit and walk emit are mutually exclusive.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.commit, cmd.walk_emit}))
        else $error("conflicting commands");

endmodule

@@ rtl/core/oost_ctrl.sv @@
// ----------------------------------------------------------------------------
// oost_ctrl
// Sequencer: one scan per operation, one scan per walk result.
// ----------------------------------------------------------------------------
module oost_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  oost_pkg::t_op    i_op,
    input  oost_pkg::t_sts   i_sts,
    output logic             o_busy,
    output oost_pkg::t_cmd   o_cmd
);
    import oost_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COMMIT, S_WSCAN, S_WEMIT} t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_op == OP_WALK) ? S_WSCAN : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_IDLE;
            end
            S_WSCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_WEMIT;
            end
            S_WEMIT: begin
                o_cmd.walk_emit = 1'b1;
                if (i_sts.walk_more && !i_sts.walk_empty) begin
                    o_cmd.walk_reset = 1'b1;
                    n_state = S_WSCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ rtl/core/oost_dp.sv @@
// ----------------------------------------------------------------------------
// oost_dp
// Slot storage, scan unit, id and sequence counters and result register.
// ----------------------------------------------------------------------------
module oost_dp #(
    parameter int SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  oost_pkg::t_req   i_req,
    input  oost_pkg::t_cmd   i_cmd,
    output oost_pkg::t_sts   o_sts,
    output logic             o_valid,
    output oost_pkg::t_rsp   o_rsp
);
    import oost_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0]   r_live, r_done;
    logic [31:0]        r_id    [SLOTS];
    logic [15:0]        r_view  [SLOTS];
    logic [31:0]        r_order [SLOTS];
    logic [63:0]        r_seq   [SLOTS];
    logic [7:0]         r_type  [SLOTS];
    logic [31:0]        r_tag   [SLOTS];
    logic [31:0]        r_param [SLOTS];
    logic [31:0]        r_next_id;
    logic [63:0]        r_next_seq;

    t_req               r_req;
    logic [IW-1:0]      r_idx;
    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic [CW-1:0]      r_cnt;
    logic [4:0]         r_emitted;
    logic [SLOTS-1:0]   r_clr;
    logic               r_valid;
    t_rsp               r_rsp;
    t_rsp               n_rsp;

    logic               view_m, cand, better;
    logic [31:0]        oa, ob;
    logic [31:0]        nid, nid2, add_id;
    logic [6:0]         cnt_w;
    logic [4:0]         emit_n, total_sat;

    assign view_m = r_live[r_idx] && (r_view[r_idx] == r_req.view_key);
    assign cand   = view_m && !r_done[r_idx];
    assign oa = r_order[r_idx] ^ 32'h8000_0000;
    assign ob = r_order[r_hit_idx] ^ 32'h8000_0000;
    // Strict less only: ties in order and sequence keep the lower slot.
    assign better = (oa < ob) || ((oa == ob) && (r_seq[r_idx] < r_seq[r_hit_idx]));

    assign nid    = r_next_id;
    assign nid2   = r_next_id + 32'd1;
    assign add_id = (nid == 32'd0) ? nid2 : nid;

    // Count of view entries widened to seven bits, enough for up to 127 slots,
    // then capped at the result limit for a walk.
    assign cnt_w     = 7'(r_cnt);
    assign total_sat = (cnt_w > 7'(MAX_RESULTS)) ? 5'(MAX_RESULTS) : 5'(cnt_w);
    assign emit_n    = r_emitted + 5'd1;

    assign o_sts.scan_done  = (r_idx == IW'(SLOTS - 1));
    assign o_sts.walk_empty = (r_cnt == '0);
    assign o_sts.walk_more  = (emit_n < total_sat);

    // Result for the commit or walk emit cycle.
    always_comb begin
        n_rsp      = '0;
        n_rsp.last = 1'b1;
        if (i_cmd.commit) begin
            unique case (t_op'(r_req.op))
                OP_ADD: begin
                    if (!r_hit) n_rsp.status = ST_FULL;
                    else n_rsp.id_out = add_id;
                end
                OP_REMOVE: begin
                    if (!r_hit) n_rsp.status = ST_NOT_FOUND;
                end
                OP_ALIVE: n_rsp.is_alive = r_hit;
                OP_COUNT: n_rsp.view_count = (cnt_w > 7'd31) ? 5'd31 : 5'(cnt_w);
                default: ;
            endcase
        end else if (i_cmd.walk_emit) begin
            if (r_cnt == '0) begin
                n_rsp.status = ST_EMPTY;
            end else begin
                n_rsp.id_out    = r_id[r_hit_idx];
                n_rsp.type_out  = r_type[r_hit_idx];
                n_rsp.tag_out   = r_tag[r_hit_idx];
                n_rsp.param_out = r_param[r_hit_idx];
                n_rsp.order_out = r_order[r_hit_idx];
                n_rsp.last      = !(emit_n < total_sat);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= '0;
            r_next_id  <= 32'd1;
            r_next_seq <= 64'd1;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.commit || i_cmd.walk_emit;
            if (i_cmd.commit || i_cmd.walk_emit) r_rsp <= n_rsp;
            if (i_cmd.load) begin
                r_req     <= i_req;
                r_idx     <= '0;
                r_hit     <= 1'b0;
                r_hit_idx <= '0;
                r_cnt     <= '0;
                r_emitted <= '0;
                r_done    <= '0;
                r_clr     <= '0;
            end
            if (i_cmd.scan) begin
                if (r_idx != IW'(SLOTS - 1)) r_idx <= r_idx + IW'(1);
                if (view_m) r_cnt <= r_cnt + CW'(1);
                unique case (t_op'(r_req.op))
                    OP_ADD: begin
                        if (!r_live[r_idx] && !r_hit) begin
                            r_hit <= 1'b1; r_hit_idx <= r_idx;
                        end
                    end
                    OP_REMOVE, OP_ALIVE: begin
                        if (r_live[r_idx] && r_req.entry_id != 32'd0 &&
                            r_id[r_idx] == r_req.entry_id && !r_hit) begin
                            r_hit <= 1'b1; r_hit_idx <= r_idx;
                        end
                    end
                    OP_CLEAR_TYPE: r_clr[r_idx] <= view_m && (r_type[r_idx] == r_req.type_code);
                    OP_CLEAR_VIEW: r_clr[r_idx] <= view_m;
                    OP_WALK: begin
                        if (cand && (!r_hit || better)) begin
                            r_hit <= 1'b1; r_hit_idx <= r_idx;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                unique case (t_op'(r_req.op))
                    OP_ADD: begin
                        if (r_hit) begin
                            r_live[r_hit_idx]  <= 1'b1;
                            r_id[r_hit_idx]    <= add_id;
                            r_view[r_hit_idx]  <= r_req.view_key;
                            r_order[r_hit_idx] <= r_req.order_key;
                            r_seq[r_hit_idx]   <= r_next_seq;
                            r_type[r_hit_idx]  <= r_req.type_code;
                            r_tag[r_hit_idx]   <= r_req.user_tag;
                            r_param[r_hit_idx] <= r_req.param_word;
                            r_next_seq <= r_next_seq + 64'd1;
                            r_next_id  <= (nid == 32'd0) ? nid + 32'd2 : nid2;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_hit) r_live[r_hit_idx] <= 1'b0;
                    end
                    OP_CLEAR_TYPE, OP_CLEAR_VIEW: r_live <= r_live & ~r_clr;
                    default: ;
                endcase
            end
            if (i_cmd.walk_emit && r_cnt != '0) begin
                r_done[r_hit_idx] <= 1'b1;
                r_emitted <= emit_n;
            end
            if (i_cmd.walk_reset) begin
                r_idx <= '0;
                r_hit <= 1'b0;
                r_cnt <= '0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

@@ sim/ordered_op_slot_table_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_op_slot_table_test
// Self-checking bench for the ordered operation slot table.
// ----------------------------------------------------------------------------
// A queue of commands, filled by the initial block, feeds a clocked driver.
// The driver sends in bursts with random gaps between them. A scoreboard model
// of the table works out the responses of each accepted command, and a clocked
// monitor compares every response strobe with the oldest expected response.
// ----------------------------------------------------------------------------
module ordered_op_slot_table_test;
    import oost_pkg::*;

    localparam int SLOTS      = 16;
    localparam int CYCLE_CAP  = 400000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_req   i_req = '0;
    logic   o_valid;
    t_rsp   o_rsp;

    ordered_op_slot_table #(.SLOTS(SLOTS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the table, kept in step with accepted transactions.
    logic               tbl_live  [SLOTS];
    logic [31:0]        tbl_id    [SLOTS];
    logic [15:0]        tbl_view  [SLOTS];
    logic signed [31:0] tbl_order [SLOTS];
    logic [63:0]        tbl_seq   [SLOTS];
    logic [7:0]         tbl_type  [SLOTS];
    logic [31:0]        tbl_tag   [SLOTS];
    logic [31:0]        tbl_param [SLOTS];
    logic [31:0]        id_ctr;
    logic [63:0]        seq_ctr;

    t_req   pending_cmds [$];
    t_rsp   expected_rsps [$];
    int     mismatches = 0;
    int     cycle_count = 0;
    logic   hold_for_drain = 1'b0;
    int     burst_left = 0;
    int     gap_left = 0;

    // Views are drawn from a small set so that entries collide and walks are long.
    logic [15:0] view_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};
    logic [31:0] recent_ids [$];

    // Applies one command to the shadow table and queues its responses.
    task automatic predict_table_op(input t_req cmd);
        t_rsp r;
        int free_idx;
        int hit;
        int total;
        int emit;
        int best;
        logic picked [SLOTS];
        logic [31:0] nid;
        r = '0;
        r.last = 1'b1;
        case (t_op'(cmd.op))
            OP_ADD: begin
                free_idx = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!tbl_live[i]) free_idx = i;
                if (free_idx < 0) begin
                    r.status = ST_FULL;
                end else begin
                    nid = id_ctr;
                    id_ctr = id_ctr + 1;
                    if (nid == 0) begin
                        nid = id_ctr;
                        id_ctr = id_ctr + 1;
                    end
                    tbl_live[free_idx]  = 1'b1;
                    tbl_id[free_idx]    = nid;
                    tbl_view[free_idx]  = cmd.view_key;
                    tbl_order[free_idx] = cmd.order_key;
                    tbl_seq[free_idx]   = seq_ctr;
                    seq_ctr = seq_ctr + 1;
                    tbl_type[free_idx]  = cmd.type_code;
                    tbl_tag[free_idx]   = cmd.user_tag;
                    tbl_param[free_idx] = cmd.param_word;
                    r.id_out = nid;
                    recent_ids.push_back(nid);
                    if (recent_ids.size() > 24) void'(recent_ids.pop_front());
                end
                expected_rsps.push_back(r);
            end
            OP_REMOVE, OP_ALIVE: begin
                hit = -1;
                if (cmd.entry_id != 0)
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (tbl_live[i] && tbl_id[i] == cmd.entry_id) hit = i;
                if (t_op'(cmd.op) == OP_REMOVE) begin
                    if (hit < 0) r.status = ST_NOT_FOUND;
                    else tbl_live[hit] = 1'b0;
                end else begin
                    r.is_alive = (hit >= 0);
                end
                expected_rsps.push_back(r);
            end
            OP_CLEAR_TYPE, OP_CLEAR_VIEW: begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_live[i] && tbl_view[i] == cmd.view_key &&
                        (t_op'(cmd.op) == OP_CLEAR_VIEW || tbl_type[i] == cmd.type_code))
                        tbl_live[i] = 1'b0;
                expected_rsps.push_back(r);
            end
            OP_COUNT: begin
                total = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_live[i] && tbl_view[i] == cmd.view_key) total++;
                r.view_count = (total > 31) ? 5'd31 : 5'(total);
                expected_rsps.push_back(r);
            end
            OP_WALK: begin
                total = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    picked[i] = 1'b0;
                    if (tbl_live[i] && tbl_view[i] == cmd.view_key) total++;
                end
                if (total == 0) begin
                    r.status = ST_EMPTY;
                    expected_rsps.push_back(r);
                end else begin
                    emit = (total > MAX_RESULTS) ? MAX_RESULTS : total;
                    for (int k = 0; k < emit; k++) begin
                        best = -1;
                        // Strict compare keeps the lower slot on a full tie.
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!tbl_live[i] || tbl_view[i] != cmd.view_key || picked[i])
                                continue;
                            if (best < 0 || tbl_order[i] < tbl_order[best] ||
                                (tbl_order[i] == tbl_order[best] &&
                                 tbl_seq[i] < tbl_seq[best]))
                                best = i;
                        end
                        picked[best] = 1'b1;
                        r = '0;
                        r.id_out    = tbl_id[best];
                        r.type_out  = tbl_type[best];
                        r.tag_out   = tbl_tag[best];
                        r.param_out = tbl_param[best];
                        r.order_out = tbl_order[best];
                        r.last      = (k + 1 == emit);
                        expected_rsps.push_back(r);
                    end
                end
            end
            default: expected_rsps.push_back(r);
        endcase
    endtask

    function automatic t_req random_cmd();
        t_req c;
        int pick;
        c.op         = 3'($urandom_range(0, 6));
        c.view_key   = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                       view_pool[$urandom_range(0, 3)];
        c.order_key  = ($urandom_range(0, 2) == 0) ? 32'($urandom) :
                       32'($signed($urandom_range(0, 6)) - 3);
        c.type_code  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        c.user_tag   = $urandom;
        c.param_word = $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 7 && recent_ids.size() > 0)
            c.entry_id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        else if (pick == 7)
            c.entry_id = 32'd0;
        else
            c.entry_id = $urandom;
        // Adds are weighted up so the table fills and walks run long.
        if ($urandom_range(0, 2) == 0) c.op = OP_ADD;
        return c;
    endfunction

    function automatic t_req make_cmd(input t_op op, input logic [15:0] view,
                                      input logic [31:0] order, input logic [7:0] typ,
                                      input logic [31:0] id);
        t_req c;
        c.op         = op;
        c.view_key   = view;
        c.order_key  = order;
        c.type_code  = typ;
        c.user_tag   = $urandom;
        c.param_word = $urandom;
        c.entry_id   = id;
        return c;
    endfunction

    // Driver: bursts of commands separated by random gaps. Start is lowered
    // during a gap, when the queue is empty, or while responses are draining.
    always @(posedge i_clk) begin
        if (i_rst_n && !(start && busy)) begin
            if (start && !busy) begin
                predict_table_op(i_req);
                void'(pending_cmds.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_cmds.size() > (start && !busy ? 0 : 0) &&
                         !(hold_for_drain && expected_rsps.size() != 0)) begin
                if (pending_cmds.size() > 0) begin
                    i_req <= pending_cmds[0];
                    start <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    start <= 1'b0;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: results cannot be stalled, so every strobe is checked at once.
    always @(posedge i_clk) begin
        t_rsp want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) begin
            if (expected_rsps.size() == 0) begin
                $error("Response with nothing expected: id_out %0h", o_rsp.id_out);
                mismatches++;
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_rsp.status);
                    mismatches++;
                end
                if (o_rsp.id_out !== want.id_out) begin
                    $error("id_out expected %0h actual %0h", want.id_out, o_rsp.id_out);
                    mismatches++;
                end
                if (o_rsp.is_alive !== want.is_alive) begin
                    $error("is_alive expected %0d actual %0d", want.is_alive, o_rsp.is_alive);
                    mismatches++;
                end
                if (o_rsp.view_count !== want.view_count) begin
                    $error("view_count expected %0d actual %0d",
                           want.view_count, o_rsp.view_count);
                    mismatches++;
                end
                if (o_rsp.type_out !== want.type_out) begin
                    $error("type_out expected %0h actual %0h", want.type_out, o_rsp.type_out);
                    mismatches++;
                end
                if (o_rsp.tag_out !== want.tag_out) begin
                    $error("tag_out expected %0h actual %0h", want.tag_out, o_rsp.tag_out);
                    mismatches++;
                end
                if (o_rsp.param_out !== want.param_out) begin
                    $error("param_out expected %0h actual %0h",
                           want.param_out, o_rsp.param_out);
                    mismatches++;
                end
                if (o_rsp.order_out !== want.order_out) begin
                    $error("order_out expected %0d actual %0d",
                           want.order_out, o_rsp.order_out);
                    mismatches++;
                end
                if (o_rsp.last !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, o_rsp.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_live[i] = 1'b0;
            tbl_id[i] = '0; tbl_view[i] = '0; tbl_order[i] = '0; tbl_seq[i] = '0;
            tbl_type[i] = '0; tbl_tag[i] = '0; tbl_param[i] = '0;
        end
        id_ctr  = 32'd1;
        seq_ctr = 64'd1;

        // Directed part: empty walk, extreme keys with ties, filling the table
        // past full, lookups of id zero and of unknown ids, clears and unused op.
        pending_cmds.push_back(make_cmd(OP_WALK, 16'hFFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ADD, 16'hFFFF, 32'h7FFFFFFF, 8'hFF, 0));
        pending_cmds.push_back(make_cmd(OP_ADD, 16'hFFFF, 32'h80000000, 8'h00, 0));
        pending_cmds.push_back(make_cmd(OP_ADD, 16'hFFFF, 32'h00000000, 8'h01, 0));
        pending_cmds.push_back(make_cmd(OP_ADD, 16'hFFFF, 32'h00000000, 8'h01, 0));
        for (int i = 0; i < 13; i++)
            pending_cmds.push_back(make_cmd(OP_ADD, 16'h0000, 32'hFFFFFFFF, 8'h01, 0));
        pending_cmds.push_back(make_cmd(OP_WALK, 16'hFFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_REMOVE, 0, 0, 0, 32'd0));
        pending_cmds.push_back(make_cmd(OP_REMOVE, 0, 0, 0, 32'hFFFFFFFF));
        pending_cmds.push_back(make_cmd(OP_ALIVE, 0, 0, 0, 32'd2));
        pending_cmds.push_back(make_cmd(OP_REMOVE, 0, 0, 0, 32'd2));
        pending_cmds.push_back(make_cmd(OP_ALIVE, 0, 0, 0, 32'd2));
        pending_cmds.push_back(make_cmd(OP_COUNT, 16'hFFFF, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_CLEAR_TYPE, 16'hFFFF, 0, 8'h01, 0));
        pending_cmds.push_back(make_cmd(OP_CLEAR_TYPE, 16'h5555, 0, 8'hAA, 0));
        pending_cmds.push_back(make_cmd(OP_NONE, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF));
        pending_cmds.push_back(make_cmd(OP_WALK, 16'h0000, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_CLEAR_VIEW, 16'h0000, 0, 0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Let the directed part drain before the random traffic starts.
        wait (pending_cmds.size() == 0);
        hold_for_drain = 1'b1;
        wait (expected_rsps.size() == 0 && !busy);
        hold_for_drain = 1'b0;
        for (int i = 0; i < 260; i++) begin
            pending_cmds.push_back(random_cmd());
            if (i == 130) begin
                wait (pending_cmds.size() == 0);
                hold_for_drain = 1'b1;
                wait (expected_rsps.size() == 0);
                hold_for_drain = 1'b0;
            end
        end
        wait (pending_cmds.size() == 0 && expected_rsps.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

@@ ordered_op_slot_table.f @@
rtl/core/oost_pkg.sv
rtl/core/oost_ctrl.sv
rtl/core/oost_dp.sv
rtl/core/ordered_op_slot_table.sv
sim/ordered_op_slot_table_test.sv
